// File: hw/rtl/plinterp_pkg.sv
`timescale 1ns / 1ps

package plinterp_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned PROD_W   = 2 * VAL_W;
  localparam int unsigned STEP_W   = $clog2(VAL_W);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_ORDER     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_APP_CHK,
    S_APP_WR,
    S_SRCH,
    S_SRCH_CMP,
    S_FETCH_LO,
    S_FETCH_HI,
    S_FETCH_DIFF,
    S_KICK,
    S_ARITH,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps

// Piecewise linear interpolation table.
// Input channel (in_valid / in_stall) carries one transaction per command:
// clear the table, append a point (time Q16.16, value Q24.8), or query the
// interpolated value at a time. Every command yields exactly one result
// transaction on the output channel (out_valid / out_stall) with the value
// and a status code.
// Flow: one command at a time; in_stall is high from acceptance until the
// result has been placed in the output register. A clear or an append to a
// full table goes straight to the result; any other append is checked
// against the last point (not on an empty table) and written if in order.
// A query runs the binary search (at most ceil(log2(points + 1)) steps, 9
// for 256 points), closes the search, reads the two bracketing points,
// starts the shared unit and waits for the multiply and 32-step restoring
// divide. A query outside the table ends after the search.
// Reset empties the table (point count zero) and drops any pending result.
// When the receiver stalls, the result holds in the output register; the
// next command may be accepted meanwhile, and its result waits until the
// register frees.
module piecewise_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_time_value,
  input  logic [31:0] in_sample_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_interp_value,
  output logic [1:0]  out_status
);

  import plinterp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  // Captured command
  logic [1:0]        op_r;
  logic [TIME_W-1:0] t_r;
  logic [VAL_W-1:0]  v_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  lo_r, hi_r;
  logic [ADDR_W-1:0] mid_r;
  status_t           status_r;
  logic [VAL_W-1:0]  res_r;

  // Interpolation operands
  logic [TIME_W-1:0] x1_r;
  logic [VAL_W-1:0]  y1_r;
  logic [TIME_W-1:0] span_r;
  logic [TIME_W-1:0] off_r;
  logic [VAL_W-1:0]  dy_r;
  logic              up_r;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  status_t           out_status_r;

  // RAM interface
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TIME_W-1:0] rd_time;
  logic [VAL_W-1:0]  rd_val;

  logic              kick;
  logic              md_done;
  logic [VAL_W-1:0]  md_quo;

  logic              accept;
  logic              out_free;
  logic              table_full;
  logic              search_live;
  logic              query_miss;
  logic [CNT_W-1:0]  mid_full;
  logic [CNT_W-1:0]  count_dec;
  logic [CNT_W-1:0]  lo_dec;

  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign table_full  = (count_r == CNT_W'(TABLE_DEPTH));
  assign search_live = (lo_r < hi_r);
  assign query_miss  = (lo_r == '0) || (lo_r >= count_r);
  assign mid_full    = lo_r + ((hi_r - lo_r) >> 1);
  assign count_dec   = count_r - 1'b1;
  assign lo_dec      = lo_r - 1'b1;

  plinterp_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TABLE_DEPTH)
  ) u_time_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (t_r),
    .rd_addr (ram_raddr),
    .rd_data (rd_time)
  );

  plinterp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (v_r),
    .rd_addr (ram_raddr),
    .rd_data (rd_val)
  );

  // Shared multiply / iterative divide unit
  plinterp_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kick),
    .mul_a    (dy_r),
    .mul_b    (off_r),
    .divisor  (span_r),
    .done     (md_done),
    .quotient (md_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_START;
      end
      S_START: begin
        case (op_r)
          OP_APPEND: begin
            if (table_full)          state_nxt = S_DONE;
            else if (count_r == '0)  state_nxt = S_APP_WR;
            else                     state_nxt = S_APP_CHK;
          end
          OP_QUERY: state_nxt = S_SRCH;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_APP_CHK: begin
        // Drop a point earlier than the last one; an equal time is kept
        state_nxt = (t_r < rd_time) ? S_DONE : S_APP_WR;
      end
      S_APP_WR:   state_nxt = S_DONE;
      S_SRCH: begin
        if (search_live)     state_nxt = S_SRCH_CMP;
        else if (query_miss) state_nxt = S_DONE;
        else                 state_nxt = S_FETCH_LO;
      end
      S_SRCH_CMP:   state_nxt = S_SRCH;
      S_FETCH_LO:   state_nxt = S_FETCH_HI;
      S_FETCH_HI:   state_nxt = S_FETCH_DIFF;
      S_FETCH_DIFF: state_nxt = S_KICK;
      S_KICK:       state_nxt = S_ARITH;
      S_ARITH: begin
        if (md_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_raddr = mid_r;
    kick      = 1'b0;
    case (state_r)
      S_IDLE:     in_stall  = 1'b0;
      S_START:    ram_raddr = count_dec[ADDR_W-1:0];
      S_APP_WR:   ram_we    = 1'b1;
      S_SRCH:     ram_raddr = mid_full[ADDR_W-1:0];
      S_FETCH_LO: ram_raddr = lo_dec[ADDR_W-1:0];
      S_FETCH_HI: ram_raddr = lo_r[ADDR_W-1:0];
      S_KICK:     kick      = 1'b1;
      default:    ram_raddr = mid_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_START && op_r == OP_CLEAR) begin
        count_r <= '0;
      end else if (state_r == S_APP_WR) begin
        count_r <= count_r + 1'b1;
      end
      // Load the result when the register frees, drop it once taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_r <= in_opcode;
          t_r  <= in_time_value;
          v_r  <= in_sample_value;
        end
      end
      S_START: begin
        res_r    <= '0;
        status_r <= (op_r == OP_APPEND && table_full) ? ST_FULL : ST_OK;
        lo_r     <= '0;
        hi_r     <= count_r;
      end
      S_APP_CHK: begin
        if (t_r < rd_time) status_r <= ST_ORDER;
      end
      S_SRCH: begin
        mid_r <= mid_full[ADDR_W-1:0];
        if (!search_live && query_miss) status_r <= ST_RANGE;
      end
      S_SRCH_CMP: begin
        // Narrow towards the first point not below the query time
        if (rd_time < t_r) lo_r <= CNT_W'(mid_r) + 1'b1;
        else               hi_r <= CNT_W'(mid_r);
      end
      S_FETCH_DIFF: begin
        x1_r <= x1_r;
      end
      S_ARITH: begin
        if (md_done) res_r <= up_r ? (y1_r + md_quo) : (y1_r - md_quo);
      end
      S_DONE: begin
        if (out_free) begin
          out_value_r  <= res_r;
          out_status_r <= status_r;
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase

    if (state_r == S_FETCH_HI) begin
      x1_r <= rd_time;
      y1_r <= rd_val;
    end
    if (state_r == S_FETCH_DIFF) begin
      span_r <= rd_time - x1_r;
      off_r  <= t_r - x1_r;
      up_r   <= (rd_val >= y1_r);
      dy_r   <= (rd_val >= y1_r) ? (rd_val - y1_r) : (y1_r - rd_val);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

// File: hw/rtl/plinterp_ram.sv
`timescale 1ns / 1ps

module plinterp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/plinterp_muldiv.sv
`timescale 1ns / 1ps

// Multiply then divide: q = (a * b) / d, truncated.
// The caller guarantees a * b < 2^32 * d, so the quotient fits 32 bits and
// the upper half of the product is already below the divisor.
module plinterp_muldiv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [plinterp_pkg::VAL_W-1:0] mul_a,
  input  logic [plinterp_pkg::VAL_W-1:0] mul_b,
  input  logic [plinterp_pkg::VAL_W-1:0] divisor,
  output logic                     done,
  output logic [plinterp_pkg::VAL_W-1:0] quotient
);

  import plinterp_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [VAL_W-1:0]  div_r;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  quo_r;
  logic [VAL_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_r, quo_r[VAL_W-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(VAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      {rem_r, quo_r} <= PROD_W'(mul_a) * PROD_W'(mul_b);
      div_r          <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? VAL_W'(trial - {1'b0, div_r}) : trial[VAL_W-1:0];
      quo_r <= {quo_r[VAL_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
